>>> rtl/tpsc_pkg.sv
// Shared widths, register index codes and the lane result type for the
// two-point sensor calibration block. No dependencies.
package tpsc_pkg;

  localparam int unsigned RAW_W      = 16;  // raw sample, raw points, scaled output
  localparam int unsigned HUM_VAL_W  = 8;   // humidity calibration values
  localparam int unsigned TEMP_VAL_W = 10;  // temperature calibration values
  localparam int unsigned VAL_MAX_W  = 10;  // widest calibration value
  // |raw - raw0| < 2^RAW_W and |value1 - value0| < 2^VAL_MAX_W
  localparam int unsigned NUM_W      = RAW_W + VAL_MAX_W;
  // one stage for magnitudes, one for the product, one per quotient bit
  localparam int unsigned LANE_STG   = 2 + NUM_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_V0  = 3'd0,
    REG_HUM_V1  = 3'd1,
    REG_TEMP_V0 = 3'd2,
    REG_TEMP_V1 = 3'd3,
    REG_HUM_R0  = 3'd4,
    REG_HUM_R1  = 3'd5,
    REG_TEMP_R0 = 3'd6,
    REG_TEMP_R1 = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [RAW_W-1:0] value;
    logic             fault;
  } lane_res_t;

endpackage

>>> rtl/tpsc_lane.sv
// One calibration lane: sign/magnitude split, product, restoring divider
// with one quotient bit per stage, then sign and offset. Uses tpsc_pkg.
module tpsc_lane import tpsc_pkg::*; #(
  parameter int unsigned VAL_W = 8
) (
  input  logic             clk_i,
  input  logic             adv_i,
  input  logic [RAW_W-1:0] sample_i,
  input  logic [VAL_W-1:0] v0_i,
  input  logic [VAL_W-1:0] v1_i,
  input  logic [RAW_W-1:0] r0_i,
  input  logic [RAW_W-1:0] r1_i,
  output lane_res_t        res_o
);

  logic [RAW_W:0]     diff;
  logic [RAW_W:0]     diff_abs;
  logic [VAL_W:0]     dv;
  logic [VAL_W:0]     dv_abs;
  logic [RAW_W:0]     den;
  logic [RAW_W:0]     den_abs;
  logic [RAW_W-1:0]   den_mag;
  logic               den_neg;

  logic [RAW_W-1:0]     a_q;
  logic [VAL_MAX_W-1:0] b_q;
  logic                 neg0_q;
  logic [NUM_W-1:0]     prod_q;
  logic                 neg1_q;

  logic [RAW_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] dq_q  [NUM_W];
  logic             neg_q [NUM_W];

  logic [RAW_W-1:0] quo;
  logic [RAW_W-1:0] quo_s;

  // operand magnitudes
  always_comb begin
    diff     = {sample_i[RAW_W-1], sample_i} - {r0_i[RAW_W-1], r0_i};
    diff_abs = diff[RAW_W] ? (~diff + 1'b1) : diff;
    dv       = {1'b0, v1_i} - {1'b0, v0_i};
    dv_abs   = dv[VAL_W] ? (~dv + 1'b1) : dv;
    den      = {r1_i[RAW_W-1], r1_i} - {r0_i[RAW_W-1], r0_i};
    den_abs  = den[RAW_W] ? (~den + 1'b1) : den;
    den_mag  = den_abs[RAW_W-1:0];
    den_neg  = den[RAW_W];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q    <= diff_abs[RAW_W-1:0];
      b_q    <= VAL_MAX_W'(dv_abs[VAL_W-1:0]);
      neg0_q <= diff[RAW_W] ^ dv[VAL_W];
      prod_q <= NUM_W'(a_q) * NUM_W'(b_q);
      neg1_q <= neg0_q;
    end
  end

  // restoring divider, MSB first
  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    logic [RAW_W-1:0] rem_in;
    logic [NUM_W-1:0] dq_in;
    logic             neg_in;
    logic [RAW_W:0]   trial;
    logic [RAW_W:0]   sub;
    logic             qbit;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = prod_q;
      assign neg_in = neg1_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dq_in  = dq_q[j-1];
      assign neg_in = neg_q[j-1];
    end

    always_comb begin
      trial = {rem_in, dq_in[NUM_W-1]};
      sub   = trial - {1'b0, den_mag};
      qbit  = (trial >= {1'b0, den_mag});
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[j] <= qbit ? sub[RAW_W-1:0] : trial[RAW_W-1:0];
        dq_q[j]  <= {dq_in[NUM_W-2:0], qbit};
        neg_q[j] <= neg_in;
      end
    end
  end

  // only the low bits of the quotient survive the 16-bit wrap
  always_comb begin
    quo         = dq_q[NUM_W-1][RAW_W-1:0];
    quo_s       = (neg_q[NUM_W-1] ^ den_neg) ? (~quo + 1'b1) : quo;
    res_o.value = RAW_W'(v0_i) + quo_s;
    res_o.fault = (r0_i == r1_i);
  end

endmodule

>>> rtl/tpsc_merge.sv
// Output stage: joins the two lane results into one request, forces the
// value of a faulted channel to zero, and holds a skid entry. Uses tpsc_pkg.
module tpsc_merge import tpsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             arr_valid_i,
  input  lane_res_t        hum_i,
  input  lane_res_t        temp_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RAW_W-1:0] hum_scaled_o,
  output logic [RAW_W-1:0] temp_scaled_o,
  output logic             hum_fault_o,
  output logic             temp_fault_o
);

  typedef struct packed {
    logic [RAW_W-1:0] hum;
    logic [RAW_W-1:0] temp;
    logic             hum_f;
    logic             temp_f;
  } out_req_t;

  out_req_t arr;
  out_req_t out_q, out_d;
  out_req_t skid_q, skid_d;
  logic     out_v_q, out_v_d;
  logic     skid_v_q, skid_v_d;
  logic     take;

  always_comb begin
    arr.hum    = hum_i.fault  ? '0 : hum_i.value;
    arr.temp   = temp_i.fault ? '0 : temp_i.value;
    arr.hum_f  = hum_i.fault;
    arr.temp_f = temp_i.fault;
  end

  always_comb begin
    take     = out_v_q && !out_stall_i;
    out_d    = out_q;
    skid_d   = skid_q;
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (take) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (arr_valid_i) begin
      if (!out_v_q || take) begin
        out_d   = arr;
        out_v_d = 1'b1;
      end else begin
        skid_d   = arr;
        skid_v_d = 1'b1;
      end
    end else if (take) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o        = skid_v_q;
  assign out_valid_o   = out_v_q;
  assign hum_scaled_o  = out_q.hum;
  assign temp_scaled_o = out_q.temp;
  assign hum_fault_o   = out_q.hum_f;
  assign temp_fault_o  = out_q.temp_f;

endmodule

>>> rtl/two_point_sensor_calibration.sv
// Two-point linear calibration, top level: configuration registers, the
// shared valid pipeline, two tpsc_lane instances and tpsc_merge. Uses tpsc_pkg.
//
// Use: each input request carries one raw humidity and one raw temperature
// sample; each gives one result request with both calibrated values and a
// fault flag per channel (set when that channel's raw points are equal, with
// the value forced to 0). Values wrap to 16 bits.
// Channels: valid/stall on both sides; a request moves on an edge with valid
// high and stall low. Configuration: cfg_we_i writes cfg_data_i into the
// register cfg_idx_i; the user must write only while no request is in
// flight, as the block itself does not enforce this. Stages: one magnitude
// stage, one multiply stage, 26 divider stages (one quotient bit each),
// then the output register.
// Throughput: one request per cycle while the pipeline is not held; the divider is fully pipelined.
// Stall: a stalled result sits in the output register while the pipeline
// keeps moving; the next arrival parks in a skid entry, and only when that
// entry is full does the whole pipeline hold and in_stall_o rise.
// Reset clears the configuration registers to 0 and empties the pipeline.
module two_point_sensor_calibration import tpsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [RAW_W-1:0]      hum_raw_i,
  input  logic [RAW_W-1:0]      temp_raw_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RAW_W-1:0]      hum_scaled_o,
  output logic [RAW_W-1:0]      temp_scaled_o,
  output logic                  hum_fault_o,
  output logic                  temp_fault_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [HUM_VAL_W-1:0]  hum_v0_q, hum_v1_q;
  logic [TEMP_VAL_W-1:0] temp_v0_q, temp_v1_q;
  logic [RAW_W-1:0]      hum_r0_q, hum_r1_q, temp_r0_q, temp_r1_q;

  logic [LANE_STG-1:0]   vld_q;
  logic                  full;
  logic                  adv;
  lane_res_t             hum_res, temp_res;

  // configuration registers; extra data bits are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hum_v0_q  <= '0;
      hum_v1_q  <= '0;
      temp_v0_q <= '0;
      temp_v1_q <= '0;
      hum_r0_q  <= '0;
      hum_r1_q  <= '0;
      temp_r0_q <= '0;
      temp_r1_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HUM_V0:  hum_v0_q  <= cfg_data_i[HUM_VAL_W-1:0];
        REG_HUM_V1:  hum_v1_q  <= cfg_data_i[HUM_VAL_W-1:0];
        REG_TEMP_V0: temp_v0_q <= cfg_data_i[TEMP_VAL_W-1:0];
        REG_TEMP_V1: temp_v1_q <= cfg_data_i[TEMP_VAL_W-1:0];
        REG_HUM_R0:  hum_r0_q  <= cfg_data_i[RAW_W-1:0];
        REG_HUM_R1:  hum_r1_q  <= cfg_data_i[RAW_W-1:0];
        REG_TEMP_R0: temp_r0_q <= cfg_data_i[RAW_W-1:0];
        REG_TEMP_R1: temp_r1_q <= cfg_data_i[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the skid entry is occupied
  assign adv        = !full;
  assign in_stall_o = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LANE_STG-2:0], in_valid_i};
    end
  end

  tpsc_lane #(
    .VAL_W (HUM_VAL_W)
  ) u_hum_lane (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .sample_i (hum_raw_i),
    .v0_i     (hum_v0_q),
    .v1_i     (hum_v1_q),
    .r0_i     (hum_r0_q),
    .r1_i     (hum_r1_q),
    .res_o    (hum_res)
  );

  tpsc_lane #(
    .VAL_W (TEMP_VAL_W)
  ) u_temp_lane (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .sample_i (temp_raw_i),
    .v0_i     (temp_v0_q),
    .v1_i     (temp_v1_q),
    .r0_i     (temp_r0_q),
    .r1_i     (temp_r1_q),
    .res_o    (temp_res)
  );

  tpsc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .arr_valid_i   (vld_q[LANE_STG-1] && adv),
    .hum_i         (hum_res),
    .temp_i        (temp_res),
    .full_o        (full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hum_scaled_o  (hum_scaled_o),
    .temp_scaled_o (temp_scaled_o),
    .hum_fault_o   (hum_fault_o),
    .temp_fault_o  (temp_fault_o)
  );

endmodule
